>>> design/hmd5_pkg.sv
// hmd5_pkg: types, constants and word functions for the HMAC-MD5 engine.
// Used by hmd5_core and hmac_md5_engine; depends on nothing.
package hmd5_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam logic [7:0] IPAD_BYTE = 8'h36;
  localparam logic [7:0] OPAD_BYTE = 8'h5c;
  localparam logic [5:0] LEN_POS = 6'd56;
  // outer hash length: pad block plus 16 digest bytes, in bits
  localparam logic [31:0] OUTER_BITS = 32'(8 * (BLOCK_BYTES + 16));

  typedef logic [3:0][31:0] chain_t;
  typedef logic [7:0][63:0] key_t;

  localparam chain_t MD5_IV = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

  typedef enum logic [3:0] {
    ST_IDLE, ST_IPAD, ST_ABS, ST_ABS_RUN, ST_FIN_A, ST_FIN_B, ST_OPAD, ST_OUT2, ST_DELIV
  } st_t;

  typedef struct packed {
    logic start;
    logic init;   // load the chain with the MD5 IV before the block
  } core_cmd_t;

  typedef struct packed {
    logic       done;
    logic [3:0] widx;   // message word the current round needs
  } core_sts_t;

  function automatic logic [31:0] md5_k(logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_rot(logic [3:0] i);
    logic [4:0] s;
    unique case (i)
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // little-endian word idx of the key block XOR pad
  function automatic logic [31:0] pad_word(key_t key, logic [3:0] idx, logic [7:0] pad);
    logic [63:0] kw;
    logic [31:0] half;
    logic [31:0] w;
    kw = key[idx[3:1]];
    half = idx[0] ? kw[31:0] : kw[63:32];
    for (int k = 0; k < 4; k++) w[8*k +: 8] = half[31-8*k -: 8] ^ pad;
    return w;
  endfunction

  // final inner block: buffered bytes below pos, 0x80 at pos, zeros, optional length
  function automatic logic [31:0] fin_word(logic [31:0] bw, logic [3:0] idx, logic [5:0] pos,
                                           logic data, logic len, logic [63:0] cnt);
    logic [31:0] w;
    logic [5:0] p;
    for (int k = 0; k < 4; k++) begin
      p = {idx, 2'(k)};
      if (data && p < pos) w[8*k +: 8] = bw[8*k +: 8];
      else if (data && p == pos) w[8*k +: 8] = 8'h80;
      else w[8*k +: 8] = 8'h00;
    end
    if (len && idx == 4'd14) w = {cnt[28:0], 3'b000};
    else if (len && idx == 4'd15) w = cnt[60:29];
    return w;
  endfunction

  function automatic logic [31:0] outer_word(chain_t inner, logic [3:0] idx);
    logic [31:0] w;
    if (idx < 4'd4) w = inner[idx[1:0]];
    else if (idx == 4'd4) w = 32'h0000_0080;
    else if (idx == 4'd14) w = OUTER_BITS;
    else w = 32'h0;
    return w;
  endfunction

  function automatic logic [31:0] bswap(logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

>>> design/hmd5_core.sv
// hmd5_core: MD5 compression, one round per cycle over a shared round unit.
// Depends on hmd5_pkg; message words are fetched from the caller by index.
module hmd5_core import hmd5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  core_cmd_t   cmd,
  input  logic [31:0] w,
  output core_sts_t   sts,
  output chain_t      h
);

  logic [31:0] a, b, c, d;
  logic [5:0]  rnd;
  logic        busy;
  logic        fin;
  logic        done;

  logic [31:0] f;
  logic [3:0]  g;
  logic [31:0] t;
  logic [63:0] tt;
  logic [4:0]  s;

  always_comb begin
    unique case (rnd[5:4])
      2'd0: begin
        f = (b & c) | (~b & d);
        g = rnd[3:0];
      end
      2'd1: begin
        f = (d & b) | (~d & c);
        g = 4'(4'd5 * rnd[3:0] + 4'd1);
      end
      2'd2: begin
        f = b ^ c ^ d;
        g = 4'(4'd3 * rnd[3:0] + 4'd5);
      end
      default: begin
        f = c ^ (b | ~d);
        g = 4'(4'd7 * rnd[3:0]);
      end
    endcase
    s = md5_rot({rnd[5:4], rnd[1:0]});
    t = a + f + md5_k(rnd) + w;
    tt = {t, t} << s;
  end

  assign sts.done = done;
  assign sts.widx = g;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      rnd  <= 6'd0;
      h    <= MD5_IV;
      done <= 1'b0;
    end else if (cmd.start && !busy) begin
      busy <= 1'b1;
      fin  <= 1'b0;
      rnd  <= 6'd0;
      done <= 1'b0;
      if (cmd.init) begin
        h <= MD5_IV;
        {d, c, b, a} <= MD5_IV;
      end else begin
        {d, c, b, a} <= h;
      end
    end else if (busy && fin) begin
      h[0] <= h[0] + a;
      h[1] <= h[1] + b;
      h[2] <= h[2] + c;
      h[3] <= h[3] + d;
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b1;
    end else if (busy) begin
      a <= d;
      d <= c;
      c <= b;
      b <= b + tt[63:32];
      rnd <= rnd + 6'd1;
      done <= 1'b0;
      if (rnd == 6'd63) fin <= 1'b1;
    end else begin
      done <= 1'b0;
    end
  end

endmodule

>>> design/hmac_md5_engine.sv
// hmac_md5_engine: HMAC-MD5 over a byte stream, top level with sequencer.
// Depends on hmd5_pkg and hmd5_core.
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------
//  in      | in_valid / in_stall   | message_byte, last_byte, no_byte
//  out     | out_valid / out_stall | digest_high, digest_low
//  cfg     | cfg_we                | cfg_index, cfg_data (key words 0..7)
//
// MD5 blocks run on the round unit: the first item of a message adds the key
// pad block, a block boundary adds one, and the last item adds one or two
// final inner blocks plus two outer blocks. Reset (rst, synchronous) closes the
// message and clears the key. A stalled result is held in the output register;
// the next item is taken meanwhile and waits only if its own result is ready.
module hmac_md5_engine import hmd5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  message_byte,
  input  logic        last_byte,
  input  logic        no_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] digest_high,
  output logic [63:0] digest_low,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  st_t state, state_next;
  key_t key;
  logic [31:0] blk [16];
  logic [63:0] cnt;
  logic [63:0] cnt_inc;
  logic        open;
  logic        launched;
  logic [7:0]  mb;
  logic        last;
  logic        nob;
  chain_t      inner;

  core_cmd_t cmd;
  core_sts_t sts;
  chain_t    h;
  logic [31:0] w;
  logic [5:0]  pos;
  logic        run;
  logic        accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign pos      = cnt[5:0];
  assign cnt_inc  = cnt + 64'd1;

  hmd5_core u_core (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .w   (w),
    .sts (sts),
    .h   (h)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (accept) state_next = open ? ST_ABS : ST_IPAD;
      ST_IPAD:    if (sts.done) state_next = ST_ABS;
      ST_ABS: begin
        priority if (!nob && cnt_inc[5:0] == 6'd0) state_next = ST_ABS_RUN;
        else if (last) state_next = ST_FIN_A;
        else state_next = ST_IDLE;
      end
      ST_ABS_RUN: if (sts.done) state_next = last ? ST_FIN_A : ST_IDLE;
      ST_FIN_A:   if (sts.done) state_next = (pos >= LEN_POS) ? ST_FIN_B : ST_OPAD;
      ST_FIN_B:   if (sts.done) state_next = ST_OPAD;
      ST_OPAD:    if (sts.done) state_next = ST_OUT2;
      ST_OUT2:    if (sts.done) state_next = ST_DELIV;
      ST_DELIV:   if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // core command and block word source
  always_comb begin
    run = 1'b0;
    cmd.init = 1'b0;
    w = 32'h0;
    unique case (state)
      ST_IPAD: begin
        run = 1'b1;
        cmd.init = 1'b1;
        w = pad_word(key, sts.widx, IPAD_BYTE);
      end
      ST_ABS_RUN: begin
        run = 1'b1;
        w = blk[sts.widx];
      end
      ST_FIN_A: begin
        run = 1'b1;
        w = fin_word(blk[sts.widx], sts.widx, pos, 1'b1, pos < LEN_POS, cnt);
      end
      ST_FIN_B: begin
        run = 1'b1;
        w = fin_word(blk[sts.widx], sts.widx, pos, 1'b0, 1'b1, cnt);
      end
      ST_OPAD: begin
        run = 1'b1;
        cmd.init = 1'b1;
        w = pad_word(key, sts.widx, OPAD_BYTE);
      end
      ST_OUT2: begin
        run = 1'b1;
        w = outer_word(inner, sts.widx);
      end
      default: begin
        run = 1'b0;
      end
    endcase
    cmd.start = run && !launched;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      key       <= '0;
      cnt       <= 64'(BLOCK_BYTES);
      open      <= 1'b0;
      launched  <= 1'b0;
      out_valid <= 1'b0;
      inner     <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) key[cfg_index] <= cfg_data;
      if (out_valid && !out_stall && state != ST_DELIV) out_valid <= 1'b0;
      if (cmd.start) launched <= 1'b1;
      if (sts.done) launched <= 1'b0;
      if (accept) begin
        mb   <= message_byte;
        last <= last_byte;
        nob  <= no_byte;
        open <= 1'b1;
      end
      if (state == ST_ABS && !nob) begin
        blk[pos[5:2]][8*pos[1:0] +: 8] <= mb;
        cnt <= cnt_inc;
      end
      // core chain still holds the inner digest when the outer pass starts
      if (state == ST_OPAD && !launched) inner <= h;
      if (state == ST_DELIV && (!out_valid || !out_stall)) begin
        out_valid   <= 1'b1;
        digest_high <= {bswap(h[0]), bswap(h[1])};
        digest_low  <= {bswap(h[2]), bswap(h[3])};
        open        <= 1'b0;
        cnt         <= 64'(BLOCK_BYTES);
      end
    end
  end

endmodule
